FILE: rtl/dlfd_pkg.sv
// Shared constants, codes and types of the multitap fractional delay line.
package dlfd_pkg;

	localparam int DEPTH_DEF       = 8192;
	localparam int TAPS_DEF        = 4;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int FUNC_W      = 2;
	localparam int TAP_IDX_W   = 3;
	localparam int SPEED_W     = 16;
	localparam int SPEED_FRAC  = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 14;
	localparam int USED_SIZE_W = 14;
	localparam int TAP_COUNT_W = 3;
	localparam int DELAY_W     = 14;
	localparam int NUM_DELAYS  = 4;
	localparam int MIN_SIZE    = 16;

	localparam logic [USED_SIZE_W-1:0] USED_SIZE_RST = 14'd8192;
	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 3'd4;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FRAC  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_USED_SIZE = 3'd0,
		REG_TAP_COUNT = 3'd1,
		REG_DELAY0    = 3'd2,
		REG_DELAY1    = 3'd3,
		REG_DELAY2    = 3'd4,
		REG_DELAY3    = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_STEP  = 2'd1,
		OP_FRAC  = 2'd2,
		OP_NULL  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [TAP_IDX_W-1:0] tap;
		logic [SPEED_W-1:0]   speed;
	} cmd_t;

endpackage

FILE: rtl/dlfd_req_if.sv
// Request channel of the delay line: valid, ready and the request fields.
interface dlfd_req_if #(
	parameter int SAMPLE_BITS = dlfd_pkg::SAMPLE_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic [dlfd_pkg::FUNC_W-1:0]       func;
	logic signed [SAMPLE_BITS-1:0]     sample_in;
	logic [dlfd_pkg::TAP_IDX_W-1:0]    tap_index;
	logic [dlfd_pkg::SPEED_W-1:0]      speed;

	modport source (output valid, func, sample_in, tap_index, speed, input ready);
	modport sink (input valid, func, sample_in, tap_index, speed, output ready);
endinterface

FILE: rtl/dlfd_rsp_if.sv
// Response channel of the delay line: valid, ready and the result fields.
interface dlfd_rsp_if #(
	parameter int SAMPLE_BITS = dlfd_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          tap_valid;

	modport source (output valid, sample_out, tap_valid, input ready);
	modport sink (input valid, sample_out, tap_valid, output ready);
endinterface

FILE: rtl/dlfd_cfg.sv
// Configuration registers, effective size and tap count, and pointer re-arm values.
module dlfd_cfg #(
	parameter int DEPTH = dlfd_pkg::DEPTH_DEF,
	parameter int TAPS  = dlfd_pkg::TAPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [dlfd_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [dlfd_pkg::CFG_DATA_W-1:0]     wr_data,
	output logic [$clog2(DEPTH+1)-1:0]          size,
	output logic [$clog2(TAPS+1)-1:0]           count,
	output logic                                arm,
	output logic [$clog2(DEPTH)-1:0]            arm_int [TAPS]
);
	localparam int AW   = $clog2(DEPTH);
	localparam int SW   = $clog2(DEPTH + 1);
	localparam int CW   = (SW > dlfd_pkg::USED_SIZE_W) ? SW : dlfd_pkg::USED_SIZE_W;
	localparam int CNTW = $clog2(TAPS + 1);
	localparam int KW   = (CNTW > dlfd_pkg::TAP_COUNT_W) ? CNTW : dlfd_pkg::TAP_COUNT_W;

	logic [dlfd_pkg::USED_SIZE_W-1:0] used_size_q, used_size_nx;
	logic [dlfd_pkg::TAP_COUNT_W-1:0] tap_count_q, tap_count_nx;
	logic [dlfd_pkg::DELAY_W-1:0]     delay_q [dlfd_pkg::NUM_DELAYS];
	logic [dlfd_pkg::DELAY_W-1:0]     delay_nx [dlfd_pkg::NUM_DELAYS];
	logic [SW-1:0]                    size_nx;

	function automatic logic [SW-1:0] clamp_size(input logic [dlfd_pkg::USED_SIZE_W-1:0] raw);
		logic [CW-1:0] v;
		v = CW'(raw);
		if (v < CW'(dlfd_pkg::MIN_SIZE)) begin
			v = CW'(dlfd_pkg::MIN_SIZE);
		end else if (v > CW'(DEPTH)) begin
			v = CW'(DEPTH);
		end
		return SW'(v);
	endfunction

	always_comb begin
		used_size_nx = used_size_q;
		tap_count_nx = tap_count_q;
		delay_nx     = delay_q;
		arm          = 1'b0;
		if (wr_en) begin
			case (wr_index)
				dlfd_pkg::REG_USED_SIZE: begin
					used_size_nx = wr_data;
					arm          = 1'b1;
				end
				dlfd_pkg::REG_TAP_COUNT: begin
					tap_count_nx = wr_data[dlfd_pkg::TAP_COUNT_W-1:0];
					arm          = 1'b1;
				end
				dlfd_pkg::REG_DELAY0: begin
					delay_nx[0] = wr_data;
					arm         = 1'b1;
				end
				dlfd_pkg::REG_DELAY1: begin
					delay_nx[1] = wr_data;
					arm         = 1'b1;
				end
				dlfd_pkg::REG_DELAY2: begin
					delay_nx[2] = wr_data;
					arm         = 1'b1;
				end
				dlfd_pkg::REG_DELAY3: begin
					delay_nx[3] = wr_data;
					arm         = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_size_q <= dlfd_pkg::USED_SIZE_RST;
			tap_count_q <= dlfd_pkg::TAP_COUNT_RST;
			for (int i = 0; i < dlfd_pkg::NUM_DELAYS; i++) begin
				delay_q[i] <= '0;
			end
		end else begin
			used_size_q <= used_size_nx;
			tap_count_q <= tap_count_nx;
			delay_q     <= delay_nx;
		end
	end

	assign size    = clamp_size(used_size_q);
	assign size_nx = clamp_size(used_size_nx);
	assign count   = (KW'(tap_count_q) > KW'(TAPS)) ? CNTW'(TAPS) : CNTW'(tap_count_q);

	// A tap starts delay samples behind the write pointer; a delay of zero or of
	// the whole size or more lands on slot zero.
	for (genvar t = 0; t < TAPS; t++) begin : g_arm
		if (t < dlfd_pkg::NUM_DELAYS) begin : g_dly
			logic [CW-1:0] d_ext;
			assign d_ext = CW'(delay_nx[t]);
			assign arm_int[t] = (d_ext == '0 || d_ext >= CW'(size_nx)) ? '0 :
				AW'(CW'(size_nx) - d_ext);
		end else begin : g_nodly
			assign arm_int[t] = '0;
		end
	end
endmodule

FILE: rtl/dlfd_front.sv
// Front end: accepts request transactions and classifies them into commands.
module dlfd_front #(
	parameter int TAPS        = dlfd_pkg::TAPS_DEF,
	parameter int SAMPLE_BITS = dlfd_pkg::SAMPLE_BITS_DEF
) (
	dlfd_req_if.sink                  req,
	input  logic [$clog2(TAPS+1)-1:0] count,
	input  logic                      clearing,
	input  logic                      q_ready,
	output logic                      push,
	output dlfd_pkg::cmd_t            cmd,
	output logic [SAMPLE_BITS-1:0]    sample
);
	localparam int CNTW = $clog2(TAPS + 1);
	localparam int KW   = (CNTW > dlfd_pkg::TAP_IDX_W) ? CNTW : dlfd_pkg::TAP_IDX_W;

	logic tap_ok;
	logic drop;

	assign req.ready = !clearing && q_ready;
	assign tap_ok    = KW'(req.tap_index) < KW'(count);

	always_comb begin
		drop      = 1'b0;
		cmd.op    = dlfd_pkg::OP_NULL;
		cmd.tap   = req.tap_index;
		cmd.speed = req.speed;
		case (req.func)
			dlfd_pkg::FUNC_WRITE: cmd.op = dlfd_pkg::OP_WRITE;
			dlfd_pkg::FUNC_STEP: begin
				if (tap_ok) begin
					cmd.op = dlfd_pkg::OP_STEP;
				end
			end
			dlfd_pkg::FUNC_FRAC: begin
				if (tap_ok) begin
					cmd.op = dlfd_pkg::OP_FRAC;
				end
			end
			default:              drop   = 1'b1;
		endcase
	end

	assign sample    = req.sample_in;
	assign push      = req.valid && req.ready && !drop;
endmodule

FILE: rtl/dlfd_fifo.sv
// Two-entry command queue between the front end and the back end.
module dlfd_fifo #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             pop_valid
);
	logic [WIDTH-1:0] data_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = data_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= push_data;
		end
	end
endmodule

FILE: rtl/dlfd_back.sv
// Back end: sample memory, write and tap pointers, interpolation pipeline and output register.
module dlfd_back #(
	parameter int DEPTH       = dlfd_pkg::DEPTH_DEF,
	parameter int TAPS        = dlfd_pkg::TAPS_DEF,
	parameter int SAMPLE_BITS = dlfd_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = dlfd_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [$clog2(DEPTH+1)-1:0]    size,
	input  logic                          arm,
	input  logic [$clog2(DEPTH)-1:0]      arm_int [TAPS],
	input  logic                          q_valid,
	input  dlfd_pkg::cmd_t                cmd,
	input  logic [SAMPLE_BITS-1:0]        sample,
	output logic                          pop,
	output logic                          clearing,
	dlfd_rsp_if.source                    rsp
);
	localparam int AW  = $clog2(DEPTH);
	localparam int SW  = $clog2(DEPTH + 1);
	localparam int PW  = AW + FRAC_BITS;
	localparam int XW  = PW + 1;
	localparam int TW  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int PRW = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int SHL = (FRAC_BITS >= dlfd_pkg::SPEED_FRAC) ? FRAC_BITS - dlfd_pkg::SPEED_FRAC : 0;
	localparam int SHR = (FRAC_BITS >= dlfd_pkg::SPEED_FRAC) ? 0 : dlfd_pkg::SPEED_FRAC - FRAC_BITS;

	typedef enum logic [1:0] {
		ST_ISSUE = 2'b01,
		ST_NEXT  = 2'b10
	} state_t;

	typedef enum logic [1:0] {
		TAG_SINGLE = 2'd0,
		TAG_A      = 2'd1,
		TAG_B      = 2'd2,
		TAG_NULL   = 2'd3
	} tag_t;

	logic [SAMPLE_BITS-1:0]        mem_q [DEPTH];
	logic signed [SAMPLE_BITS-1:0] rdata_q;

	state_t                        st_q;
	logic                          clr_busy_q;
	logic [AW-1:0]                 clr_addr_q;
	logic [AW-1:0]                 wp_q;
	logic [PW-1:0]                 ptr_q [TAPS];
	logic [AW-1:0]                 i1_q;
	logic signed [PRW-1:0]         pa_q;

	logic                          valid_s1;
	tag_t                          tag_s1;
	logic [FRAC_BITS-1:0]          f_s1;
	logic                          valid_s2;
	logic                          frac_s2;
	logic                          tapv_s2;
	logic [SAMPLE_BITS-1:0]        val_s2;
	logic signed [PRW-1:0]         pa_s2;
	logic signed [PRW-1:0]         pb_s2;
	logic                          rsp_valid_q;
	logic [SAMPLE_BITS-1:0]        sample_out_q;
	logic                          tap_valid_q;

	logic                          advance;
	logic [PW-1:0]                 ptr_cur;
	logic [XW-1:0]                 speed_fx;
	logic [XW-1:0]                 inc;
	logic [XW-1:0]                 sum;
	logic [XW-1:0]                 limit;
	logic [PW-1:0]                 p_new;
	logic [AW-1:0]                 i0;
	logic [FRAC_BITS-1:0]          f_new;
	logic [SW-1:0]                 i0_inc;
	logic [AW-1:0]                 i1;
	logic [SW-1:0]                 wp_inc;
	logic [AW-1:0]                 wp_next;
	logic                          mem_we;
	logic                          mem_re;
	logic [AW-1:0]                 mem_addr;
	logic [SAMPLE_BITS-1:0]        mem_wdata;
	logic [FRAC_BITS:0]            w_a;
	logic signed [PRW-1:0]         prod_a;
	logic signed [PRW-1:0]         prod_b;
	logic signed [PRW:0]           acc;

	assign advance  = !rsp_valid_q || rsp.ready;
	assign pop      = advance && !clr_busy_q && (st_q == ST_ISSUE) && q_valid;
	assign clearing = clr_busy_q;

	// Pointer step. The pointer sits below the limit and a step is below
	// sixteen samples, so one conditional subtract wraps it.
	assign ptr_cur  = ptr_q[cmd.tap[TW-1:0]];
	assign speed_fx = (XW'(cmd.speed) << SHL) >> SHR;
	assign inc      = (cmd.op == dlfd_pkg::OP_STEP) ? (XW'(1) << FRAC_BITS) : speed_fx;
	assign sum      = XW'(ptr_cur) + inc;
	assign limit    = XW'(size) << FRAC_BITS;
	assign p_new    = (sum >= limit) ? PW'(sum - limit) : PW'(sum);
	assign i0       = p_new[PW-1:FRAC_BITS];
	assign f_new    = p_new[FRAC_BITS-1:0];
	assign i0_inc   = SW'(i0) + SW'(1);
	assign i1       = (i0_inc == size) ? '0 : AW'(i0_inc);
	assign wp_inc   = SW'(wp_q) + SW'(1);
	assign wp_next  = (wp_inc == size) ? '0 : AW'(wp_inc);

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = i0;
		mem_wdata = sample;
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_addr  = clr_addr_q;
			mem_wdata = '0;
		end else if (advance && st_q == ST_NEXT) begin
			mem_re   = 1'b1;
			mem_addr = i1_q;
		end else if (pop) begin
			case (cmd.op)
				dlfd_pkg::OP_WRITE: begin
					mem_we   = 1'b1;
					mem_addr = wp_next;
				end
				dlfd_pkg::OP_STEP, dlfd_pkg::OP_FRAC: mem_re = 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			for (int t = 0; t < TAPS; t++) begin
				ptr_q[t] <= '0;
			end
		end else if (arm) begin
			wp_q <= '0;
			for (int t = 0; t < TAPS; t++) begin
				ptr_q[t] <= PW'(arm_int[t]) << FRAC_BITS;
			end
		end else if (pop) begin
			if (cmd.op == dlfd_pkg::OP_WRITE) begin
				wp_q <= wp_next;
			end else if (cmd.op == dlfd_pkg::OP_STEP || cmd.op == dlfd_pkg::OP_FRAC) begin
				ptr_q[cmd.tap[TW-1:0]] <= p_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_ISSUE;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			if (st_q == ST_NEXT) begin
				st_q <= ST_ISSUE;
			end else if (pop && cmd.op == dlfd_pkg::OP_FRAC) begin
				st_q <= ST_NEXT;
			end
			valid_s1    <= (st_q == ST_NEXT) || (pop && cmd.op != dlfd_pkg::OP_WRITE);
			valid_s2    <= valid_s1 && tag_s1 != TAG_A;
			rsp_valid_q <= valid_s2;
		end
	end

	// Interpolation in signed form: a*(1-f) when the first neighbour arrives,
	// b*f when the second does, then the rounded sum.
	assign w_a    = (FRAC_BITS+1)'(1) << FRAC_BITS;
	assign prod_a = $signed(rdata_q) * $signed({1'b0, w_a - (FRAC_BITS+1)'(f_s1)});
	assign prod_b = $signed(rdata_q) * $signed({1'b0, f_s1});
	assign acc    = (PRW+1)'(pa_s2) + (PRW+1)'(pb_s2) + ((PRW+1)'(1) << (FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		if (advance) begin
			if (st_q == ST_NEXT) begin
				tag_s1 <= TAG_B;
			end else if (pop) begin
				f_s1 <= f_new;
				i1_q <= i1;
				case (cmd.op)
					dlfd_pkg::OP_STEP: tag_s1 <= TAG_SINGLE;
					dlfd_pkg::OP_FRAC: tag_s1 <= TAG_A;
					default:           tag_s1 <= TAG_NULL;
				endcase
			end
			if (valid_s1 && tag_s1 == TAG_A) begin
				pa_q <= prod_a;
			end
			frac_s2      <= tag_s1 == TAG_B;
			tapv_s2      <= tag_s1 != TAG_NULL;
			val_s2       <= (tag_s1 == TAG_NULL) ? '0 : rdata_q;
			pa_s2        <= pa_q;
			pb_s2        <= prod_b;
			sample_out_q <= frac_s2 ? acc[FRAC_BITS +: SAMPLE_BITS] : val_s2;
			tap_valid_q  <= tapv_s2;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.sample_out = sample_out_q;
	assign rsp.tap_valid  = tap_valid_q;

	a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !pop && !mem_re)
		else $error("Command issued during the memory clear.");

	a_second_read: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && st_q == ST_NEXT) |=> (valid_s1 && tag_s1 == TAG_B))
		else $error("Second neighbour read did not follow the first.");

	a_first_then_next: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && tag_s1 == TAG_A) |-> (st_q == ST_NEXT))
		else $error("First neighbour in flight without a pending second read.");

	a_wp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(wp_q) < size)
		else $error("Write pointer beyond the used size.");
endmodule

FILE: rtl/multitap_fractional_delay_line_core.sv
// Top level of the multitap fractional delay line: configuration, front end, queue and back end.
//
//   Channel | Direction | Transaction fields                      | Handshake
//   req     | sink      | func, sample_in, tap_index, speed       | valid/ready
//   rsp     | source    | sample_out, tap_valid                   | valid/ready
//   cfg     | sink      | cfg_index, cfg_data                     | cfg_wr_en only
//
// A fractional read holds the memory port in the ST_NEXT state for its second neighbour,
// so the next command waits: both neighbouring samples come from the one sample memory port.
// A read result passes the memory read register with stage one, then stage two, then the
// output register before it is offered; a fractional result follows its second read.
// After reset the memory is cleared address by address, during which req.ready is low.
// A stalled response freezes the back end; the two-entry queue takes requests until full.
module multitap_fractional_delay_line_core #(
	parameter int DEPTH       = dlfd_pkg::DEPTH_DEF,
	parameter int TAPS        = dlfd_pkg::TAPS_DEF,
	parameter int SAMPLE_BITS = dlfd_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = dlfd_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [dlfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dlfd_pkg::CFG_DATA_W-1:0] cfg_data,
	dlfd_req_if.sink                        req,
	dlfd_rsp_if.source                      rsp
);
	localparam int AW   = $clog2(DEPTH);
	localparam int SW   = $clog2(DEPTH + 1);
	localparam int CNTW = $clog2(TAPS + 1);
	localparam int CMDW = $bits(dlfd_pkg::cmd_t);
	localparam int QW   = CMDW + SAMPLE_BITS;

	logic [SW-1:0]          size;
	logic [CNTW-1:0]        count;
	logic                   arm;
	logic [AW-1:0]          arm_int [TAPS];
	logic                   clearing;
	logic                   q_ready;
	logic                   push;
	dlfd_pkg::cmd_t         f_cmd;
	logic [SAMPLE_BITS-1:0] f_sample;
	logic [QW-1:0]          q_data;
	logic                   q_valid;
	logic                   pop;
	dlfd_pkg::cmd_t         b_cmd;
	logic [SAMPLE_BITS-1:0] b_sample;

	dlfd_cfg #(
		.DEPTH (DEPTH),
		.TAPS  (TAPS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.size     (size),
		.count    (count),
		.arm      (arm),
		.arm_int  (arm_int)
	);

	dlfd_front #(
		.TAPS        (TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.req      (req),
		.count    (count),
		.clearing (clearing),
		.q_ready  (q_ready),
		.push     (push),
		.cmd      (f_cmd),
		.sample   (f_sample)
	);

	dlfd_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({f_cmd, f_sample}),
		.push_ready (q_ready),
		.pop        (pop),
		.pop_data   (q_data),
		.pop_valid  (q_valid)
	);

	assign b_cmd    = dlfd_pkg::cmd_t'(q_data[QW-1:SAMPLE_BITS]);
	assign b_sample = q_data[SAMPLE_BITS-1:0];

	dlfd_back #(
		.DEPTH       (DEPTH),
		.TAPS        (TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.size     (size),
		.arm      (arm),
		.arm_int  (arm_int),
		.q_valid  (q_valid),
		.cmd      (b_cmd),
		.sample   (b_sample),
		.pop      (pop),
		.clearing (clearing),
		.rsp      (rsp)
	);
endmodule
